// ===== src/rgb5a3b_pkg.sv =====
// Shared constants, types and register codes for the RGB5A3 banner decoder.
// No dependencies.
package rgb5a3b_pkg;

    localparam int BANNER_WIDTH  = 96;
    localparam int BANNER_HEIGHT = 32;

    localparam int TILE_COLS = (BANNER_WIDTH / 4) > 0 ? (BANNER_WIDTH / 4) : 1;
    localparam int TILE_ROWS = (BANNER_HEIGHT / 4) > 0 ? (BANNER_HEIGHT / 4) : 1;
    localparam int COL_W     = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int ROW_W     = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    localparam int NUM_LANES = 4;
    localparam int IDX_W     = 12;
    localparam int TEXEL_W   = 16;
    localparam int PIX_W     = 32;
    localparam int COLOR_W   = 24;

    localparam logic [1:0] CFG_SMALL_ICONS     = 2'd0;
    localparam logic [1:0] CFG_PIXEL_FORMAT    = 2'd1;
    localparam logic [1:0] CFG_WINDOW_COLOR    = 2'd2;
    localparam logic [1:0] CFG_HIGHLIGHT_COLOR = 2'd3;

    localparam logic [1:0] FMT_8BIT   = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_RGB24  = 2'd2;
    localparam logic [1:0] FMT_RGB32  = 2'd3;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        t_rgb norm;
        t_rgb high;
    } t_lane_out;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             half;
        logic             done;
    } t_meta;

endpackage

// ===== src/r5b_lane.sv =====
// One texel decode lane: byte swap, 555 widening or 3-bit alpha blend over
// the window and highlight colors. Two register stages. Uses rgb5a3b_pkg.
module r5b_lane (
    input  logic                               i_clk,
    input  logic                               i_en1,
    input  logic                               i_en2,
    input  logic [rgb5a3b_pkg::TEXEL_W-1:0]    i_texel,
    input  rgb5a3b_pkg::t_rgb                  i_window,
    input  rgb5a3b_pkg::t_rgb                  i_highlight,
    output rgb5a3b_pkg::t_lane_out             o_pix
);
    import rgb5a3b_pkg::*;

    localparam logic [13:0] RECIP7 = 14'd9363;

    logic [15:0]        p;
    logic [2:0]         alpha;
    logic [2:0]         inv_alpha;
    logic               n_opq;
    t_rgb               n_wide;
    logic [2:0][10:0]   n_num_n;
    logic [2:0][10:0]   n_num_h;
    logic [2:0][10:0]   fg;

    logic               r_opq;
    t_rgb               r_wide;
    logic [2:0][10:0]   r_num_n;
    logic [2:0][10:0]   r_num_h;
    t_lane_out          r_pix;
    t_lane_out          n_pix;

    function automatic logic [7:0] div7(input logic [10:0] num);
        logic [24:0] prod;
        prod = 25'(num) * 25'(RECIP7);
        return prod[23:16];
    endfunction

    always_comb begin
        p         = {i_texel[7:0], i_texel[15:8]};
        n_opq     = p[15];
        alpha     = p[14:12];
        inv_alpha = 3'd7 - alpha;
        for (int ch = 0; ch < 3; ch++) begin
            n_wide[ch]  = {p[5*ch +: 5], p[5*ch+2 +: 3]};
            fg[ch]      = 11'({p[4*ch +: 4], 4'b0}) * 11'(alpha);
            n_num_n[ch] = fg[ch] + 11'(i_window[ch]) * 11'(inv_alpha);
            n_num_h[ch] = fg[ch] + 11'(i_highlight[ch]) * 11'(inv_alpha);
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (r_opq) begin
                n_pix.norm[ch] = r_wide[ch];
                n_pix.high[ch] = r_wide[ch];
            end else begin
                n_pix.norm[ch] = div7(r_num_n[ch]);
                n_pix.high[ch] = div7(r_num_h[ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_opq   <= n_opq;
            r_wide  <= n_wide;
            r_num_n <= n_num_n;
            r_num_h <= n_num_h;
        end
        if (i_en2) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== src/r5b_merge.sv =====
// Merge stage: holds the four lane results, averages them in small mode,
// selects one pixel and packs it. Uses rgb5a3b_pkg.
module r5b_merge (
    input  logic                                                i_clk,
    input  logic                                                i_load,
    input  logic                                                i_small,
    input  rgb5a3b_pkg::t_lane_out [rgb5a3b_pkg::NUM_LANES-1:0] i_lanes,
    input  logic [1:0]                                          i_sel,
    input  logic [1:0]                                          i_fmt,
    output logic [rgb5a3b_pkg::PIX_W-1:0]                       o_normal,
    output logic [rgb5a3b_pkg::PIX_W-1:0]                       o_highlight
);
    import rgb5a3b_pkg::*;

    t_lane_out [NUM_LANES-1:0] r_pix;
    t_lane_out [NUM_LANES-1:0] n_pix;
    t_lane_out                 avg;
    t_lane_out                 cur;
    logic [9:0]                sum_n;
    logic [9:0]                sum_h;

    function automatic logic [PIX_W-1:0] pack(input t_rgb c, input logic [1:0] fmt);
        logic [PIX_W-1:0] res;
        unique case (fmt)
            FMT_8BIT:   res = {24'b0, c[2] | (c[1] ^ c[0])};
            FMT_RGB565: res = {16'b0, c[2][7:3], c[1][7:2], c[0][7:3]};
            FMT_RGB24:  res = {8'b0, c[2], c[1], c[0]};
            FMT_RGB32:  res = {8'hFF, c[2], c[1], c[0]};
            default:    res = '0;
        endcase
        return res;
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_n = '0;
            sum_h = '0;
            for (int l = 0; l < NUM_LANES; l++) begin
                sum_n = sum_n + 10'(i_lanes[l].norm[ch]);
                sum_h = sum_h + 10'(i_lanes[l].high[ch]);
            end
            avg.norm[ch] = sum_n[9:2];
            avg.high[ch] = sum_h[9:2];
        end
        n_pix = i_lanes;
        if (i_small) begin
            n_pix[0] = avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= n_pix;
        end
    end

    always_comb begin
        cur         = r_pix[i_sel];
        o_normal    = pack(cur.norm, i_fmt);
        o_highlight = (i_fmt == FMT_8BIT) ? pack(cur.norm, i_fmt) : pack(cur.high, i_fmt);
    end

endmodule

// ===== src/rgb5a3_banner_to_rgb_unit.sv =====
// Top level of the RGB5A3 banner decoder: config registers, tile/quad
// counters, four decode lanes, merge stage and output register.
// Uses rgb5a3b_pkg, r5b_lane, r5b_merge.
//
// Each transfer on the input carries one 2x2 quad of a 4x4-tiled banner,
// quads in tile order and tiles left to right, top to bottom; position
// counters wrap after the last quad. Four lanes decode the texels in
// parallel. In small mode one averaged pixel comes out per quad, so a quad
// can be taken every cycle while the output is not stalled; in large mode
// four pixels come out one per cycle while not stalled, and the merge stage
// feeding the single output register holds each quad until its last pixel
// has gone out. Configuration writes are always ready and must only happen
// while the block is idle.
module rgb5a3_banner_to_rgb_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [rgb5a3b_pkg::COLOR_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rgb5a3b_pkg::TEXEL_W-1:0]     i_texel_top_left,
    input  logic [rgb5a3b_pkg::TEXEL_W-1:0]     i_texel_top_right,
    input  logic [rgb5a3b_pkg::TEXEL_W-1:0]     i_texel_bottom_left,
    input  logic [rgb5a3b_pkg::TEXEL_W-1:0]     i_texel_bottom_right,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rgb5a3b_pkg::IDX_W-1:0]       o_pixel_index,
    output logic [rgb5a3b_pkg::PIX_W-1:0]       o_normal_pixel,
    output logic [rgb5a3b_pkg::PIX_W-1:0]       o_highlight_pixel,
    output logic                                o_last_of_item,
    output logic                                o_banner_done
);
    import rgb5a3b_pkg::*;

    localparam logic [IDX_W-1:0] W_FULL = IDX_W'(BANNER_WIDTH);
    localparam logic [IDX_W-1:0] W_HALF = IDX_W'(BANNER_WIDTH / 2);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(TILE_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TILE_ROWS - 1);

    // config
    logic               r_small;
    logic [1:0]         r_fmt;
    t_rgb               r_window;
    t_rgb               r_highlight;

    // position
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [1:0]         r_quad;

    // pipeline control
    logic               r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    logic               n_s1_valid, n_s2_valid, n_s3_valid, n_o_valid;
    t_meta              r_s1_meta, r_s2_meta, r_s3_meta;
    t_meta              n_meta;
    logic [1:0]         r_s3_q;
    logic [IDX_W-1:0]   r_o_idx;
    logic [PIX_W-1:0]   r_o_norm;
    logic [PIX_W-1:0]   r_o_high;
    logic               r_o_last;
    logic               r_o_done;

    logic               out_rdy, s3_emit, s3_last, s3_rdy;
    logic               s2_mv, s2_rdy, s1_mv, s1_rdy, in_acc;

    logic [IDX_W-1:0]   y0, x0, ys, xs, cur_idx;
    logic [2*IDX_W-1:0] prod_full, prod_half;

    logic [NUM_LANES-1:0][TEXEL_W-1:0] texels;
    t_lane_out [NUM_LANES-1:0]         lane_pix;
    logic [PIX_W-1:0]                  mrg_norm;
    logic [PIX_W-1:0]                  mrg_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small     <= 1'b0;
            r_fmt       <= FMT_RGB32;
            r_window    <= 24'hFFFFFF;
            r_highlight <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SMALL_ICONS:     r_small     <= i_cfg_data[0];
                CFG_PIXEL_FORMAT:    r_fmt       <= i_cfg_data[1:0];
                CFG_WINDOW_COLOR:    r_window    <= i_cfg_data;
                CFG_HIGHLIGHT_COLOR: r_highlight <= i_cfg_data;
                default:             r_small     <= r_small;
            endcase
        end
    end

    // handshake chain
    always_comb begin
        out_rdy    = !r_o_valid || !i_out_stall;
        s3_emit    = r_s3_valid && out_rdy;
        s3_last    = r_s3_meta.half || (r_s3_q == 2'd3);
        s3_rdy     = !r_s3_valid || (s3_emit && s3_last);
        s2_mv      = r_s2_valid && s3_rdy;
        s2_rdy     = !r_s2_valid || s3_rdy;
        s1_mv      = r_s1_valid && s2_rdy;
        s1_rdy     = !r_s1_valid || s2_rdy;
        in_acc     = i_in_valid && s1_rdy;
        n_s1_valid = in_acc || (r_s1_valid && !s2_rdy);
        n_s2_valid = s1_mv || (r_s2_valid && !s3_rdy);
        n_s3_valid = s2_mv || (r_s3_valid && !(s3_emit && s3_last));
        n_o_valid  = s3_emit || (r_o_valid && i_out_stall);
    end

    assign o_in_stall = !s1_rdy;

    // index of the quad's first pixel, kept to 12 bits
    always_comb begin
        y0        = IDX_W'({r_row, r_quad[1], 1'b0});
        x0        = IDX_W'({r_col, r_quad[0], 1'b0});
        ys        = IDX_W'({r_row, r_quad[1]});
        xs        = IDX_W'({r_col, r_quad[0]});
        prod_full = y0 * W_FULL;
        prod_half = ys * W_HALF;
        n_meta.half  = r_small;
        n_meta.done  = (r_quad == 2'd3) && (r_col == COL_LAST) && (r_row == ROW_LAST);
        n_meta.idx   = r_small ? prod_half[IDX_W-1:0] + xs : prod_full[IDX_W-1:0] + x0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_quad <= '0;
        end else if (in_acc) begin
            r_quad <= r_quad + 2'd1;
            if (r_quad == 2'd3) begin
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    r_row <= (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_s3_q     <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
            r_s3_valid <= n_s3_valid;
            r_o_valid  <= n_o_valid;
            if (s2_mv) begin
                r_s3_q <= '0;
            end else if (s3_emit) begin
                r_s3_q <= r_s3_q + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_meta <= n_meta;
        end
        if (s1_mv) begin
            r_s2_meta <= r_s1_meta;
        end
        if (s2_mv) begin
            r_s3_meta <= r_s2_meta;
        end
        if (s3_emit) begin
            r_o_idx  <= cur_idx;
            r_o_norm <= mrg_norm;
            r_o_high <= mrg_high;
            r_o_last <= s3_last;
            r_o_done <= s3_last && r_s3_meta.done;
        end
    end

    always_comb begin
        cur_idx = r_s3_meta.idx + (r_s3_q[1] ? W_FULL : '0) + IDX_W'(r_s3_q[0]);
    end

    assign texels = {i_texel_bottom_right, i_texel_bottom_left,
                     i_texel_top_right, i_texel_top_left};

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        r5b_lane u_lane (
            .i_clk       (i_clk),
            .i_en1       (in_acc),
            .i_en2       (s1_mv),
            .i_texel     (texels[l]),
            .i_window    (r_window),
            .i_highlight (r_highlight),
            .o_pix       (lane_pix[l])
        );
    end

    r5b_merge u_merge (
        .i_clk       (i_clk),
        .i_load      (s2_mv),
        .i_small     (r_s2_meta.half),
        .i_lanes     (lane_pix),
        .i_sel       (r_s3_q),
        .i_fmt       (r_fmt),
        .o_normal    (mrg_norm),
        .o_highlight (mrg_high)
    );

    assign o_out_valid       = r_o_valid;
    assign o_pixel_index     = r_o_idx;
    assign o_normal_pixel    = r_o_norm;
    assign o_highlight_pixel = r_o_high;
    assign o_last_of_item    = r_o_last;
    assign o_banner_done     = r_o_done;

endmodule

// ===== verif/tb_rgb5a3_banner_to_rgb_unit.sv =====
// Testbench for rgb5a3_banner_to_rgb_unit: directed quads, then random quads under
// several register settings, checked pixel by pixel against a local decoder model.
// Depends on rgb5a3b_pkg and the decoder RTL.
module tb_rgb5a3_banner_to_rgb_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb5a3b_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] norm;
        logic [PIX_W-1:0] high;
        logic             last;
        logic             done;
    } t_banner_pixel;

    typedef struct packed {
        logic [TEXEL_W-1:0] tl;
        logic [TEXEL_W-1:0] tr;
        logic [TEXEL_W-1:0] bl;
        logic [TEXEL_W-1:0] br;
        logic               typed;
        logic [PIX_W-1:0]   tl_norm;
        logic [PIX_W-1:0]   tl_high;
    } t_quad_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [COLOR_W-1:0]    i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [TEXEL_W-1:0]    i_texel_top_left;
    logic [TEXEL_W-1:0]    i_texel_top_right;
    logic [TEXEL_W-1:0]    i_texel_bottom_left;
    logic [TEXEL_W-1:0]    i_texel_bottom_right;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [IDX_W-1:0]      o_pixel_index;
    logic [PIX_W-1:0]      o_normal_pixel;
    logic [PIX_W-1:0]      o_highlight_pixel;
    logic                  o_last_of_item;
    logic                  o_banner_done;

    // decoder model state
    logic                  small_mode;
    logic [1:0]            pix_format;
    logic [COLOR_W-1:0]    win_color;
    logic [COLOR_W-1:0]    hil_color;
    int                    tile_col;
    int                    tile_row;
    logic [1:0]            quad_num;

    t_banner_pixel         pending_pixels[$];
    int                    errors;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    hold_asked;
    int                    hold_taken;
    int                    hold_left;

    // default registers: large, 32-bit, white window, black highlight
    t_quad_row directed_rows [0:11] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hFFFFFFFF, 32'hFF000000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF},
        '{16'h0080, 16'h8000, 16'hFF7F, 16'h7FFF, 1'b1, 32'hFF000000, 32'hFF000000},
        '{16'hFF70, 16'h0F70, 16'hF070, 16'h0070, 1'b1, 32'hFF00F0F0, 32'hFF00F0F0},
        '{16'h007F, 16'h00FC, 16'hE07F, 16'h1F80, 1'b1, 32'hFFF00000, 32'hFFF00000},
        '{16'h00FC, 16'hE083, 16'h1F80, 16'h0080, 1'b1, 32'hFFFF0000, 32'hFFFF0000},
        '{16'h5A3C, 16'h0136, 16'hA520, 16'h4C18, 1'b0, 32'h0, 32'h0},
        '{16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b0, 32'h0, 32'h0},
        '{16'h0050, 16'h0060, 16'hAA5A, 16'h55A5, 1'b0, 32'h0, 32'h0},
        '{16'hFF0F, 16'hF00F, 16'h0FFF, 16'h3C4B, 1'b0, 32'h0, 32'h0},
        '{16'h9E51, 16'h2773, 16'h8181, 16'h7E7E, 1'b0, 32'h0, 32'h0},
        '{16'hC3A9, 16'h1B62, 16'h6D45, 16'hF4D8, 1'b0, 32'h0, 32'h0}
    };

    rgb5a3_banner_to_rgb_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_texel_top_left     (i_texel_top_left),
        .i_texel_top_right    (i_texel_top_right),
        .i_texel_bottom_left  (i_texel_bottom_left),
        .i_texel_bottom_right (i_texel_bottom_right),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_pixel_index        (o_pixel_index),
        .o_normal_pixel       (o_normal_pixel),
        .o_highlight_pixel    (o_highlight_pixel),
        .o_last_of_item       (o_last_of_item),
        .o_banner_done        (o_banner_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void decode_texel(input logic [TEXEL_W-1:0] raw,
                                         output t_rgb nrm, output t_rgb hil);
        logic [15:0] p;
        int a;
        int c;
        p = {raw[7:0], raw[15:8]};
        a = p[14:12];
        for (int k = 0; k < 3; k++) begin
            if (p[15]) begin
                c = (p >> (5 * k)) & 31;
                nrm[k] = 8'((c << 3) | (c >> 2));
                hil[k] = nrm[k];
            end else begin
                c = (p >> (4 * k)) & 15;
                nrm[k] = 8'((16 * c * a + int'(win_color[8*k +: 8]) * (7 - a)) / 7);
                hil[k] = 8'((16 * c * a + int'(hil_color[8*k +: 8]) * (7 - a)) / 7);
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] pack_pixel(input t_rgb c);
        case (pix_format)
            FMT_8BIT:   return {24'd0, c[2] | (c[1] ^ c[0])};
            FMT_RGB565: return {16'd0, c[2][7:3], c[1][7:2], c[0][7:3]};
            FMT_RGB24:  return {8'd0, c[2], c[1], c[0]};
            default:    return {8'hFF, c[2], c[1], c[0]};
        endcase
    endfunction

    function automatic void push_pixel(input int idx, input t_rgb nrm, input t_rgb hil,
                                       input logic last, input logic done);
        t_banner_pixel px;
        px.idx  = IDX_W'(idx);
        px.norm = pack_pixel(nrm);
        px.high = (pix_format == FMT_8BIT) ? pack_pixel(nrm) : pack_pixel(hil);
        px.last = last;
        px.done = done;
        pending_pixels = {pending_pixels, px};
    endfunction

    function automatic void predict_quad(input logic [3:0][TEXEL_W-1:0] tex);
        t_rgb nrm [4];
        t_rgb hil [4];
        t_rgb avg_n;
        t_rgb avg_h;
        int   y0;
        int   x0;
        int   sn;
        int   sh;
        logic done;
        y0 = tile_row * 4 + quad_num[1] * 2;
        x0 = tile_col * 4 + quad_num[0] * 2;
        for (int q = 0; q < 4; q++) decode_texel(tex[3-q], nrm[q], hil[q]);
        done = (quad_num == 2'd3) && (tile_col + 1 >= TILE_COLS) && (tile_row + 1 >= TILE_ROWS);
        if (small_mode) begin
            for (int k = 0; k < 3; k++) begin
                sn = 0;
                sh = 0;
                for (int q = 0; q < 4; q++) begin
                    sn += nrm[q][k];
                    sh += hil[q][k];
                end
                avg_n[k] = 8'(sn >> 2);
                avg_h[k] = 8'(sh >> 2);
            end
            push_pixel((y0 / 2) * (BANNER_WIDTH / 2) + x0 / 2, avg_n, avg_h, 1'b1, done);
        end else begin
            for (int q = 0; q < 4; q++) begin
                push_pixel((y0 + q / 2) * BANNER_WIDTH + x0 + q % 2, nrm[q], hil[q],
                           q == 3, (q == 3) && done);
            end
        end
        quad_num = quad_num + 2'd1;
        if (quad_num == 2'd0) begin
            tile_col++;
            if (tile_col >= TILE_COLS) begin
                tile_col = 0;
                tile_row++;
                if (tile_row >= TILE_ROWS) tile_row = 0;
            end
        end
    endfunction

    function automatic logic [TEXEL_W-1:0] rand_texel();
        logic [TEXEL_W-1:0] r;
        r = TEXEL_W'($urandom);
        case ($urandom_range(7))
            0:       r = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2, 3: r[7] = 1'b1;
            4, 5, 6: r[7] = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_quad(input logic [3:0][TEXEL_W-1:0] tex, input logic typed = 1'b0,
                             input logic [PIX_W-1:0] tl_norm = '0,
                             input logic [PIX_W-1:0] tl_high = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_texel_top_left     <= tex[3];
        i_texel_top_right    <= tex[2];
        i_texel_bottom_left  <= tex[1];
        i_texel_bottom_right <= tex[0];
        do @(posedge i_clk); while (o_in_stall);
        predict_quad(tex);
        if (typed) begin
            pending_pixels[pending_pixels.size() - 4].norm = tl_norm;
            pending_pixels[pending_pixels.size() - 4].high = tl_high;
        end
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_pixels();
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic sm, input logic [1:0] fmt,
                                 input logic [COLOR_W-1:0] win,
                                 input logic [COLOR_W-1:0] hi);
        logic [COLOR_W-1:0] vals [4];
        vals = '{COLOR_W'(sm), COLOR_W'(fmt), win, hi};
        @(negedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (2'(k))
                CFG_SMALL_ICONS:  small_mode = vals[k][0];
                CFG_PIXEL_FORMAT: pix_format = vals[k][1:0];
                CFG_WINDOW_COLOR: win_color  = vals[k];
                default:          hil_color  = vals[k];
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_quads(input int count, input int hold_at = -1, input int pause_at = -1);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_asked++;
            if (n == pause_at) begin
                end_burst();
                drain_pixels();
            end
            send_quad({rand_texel(), rand_texel(), rand_texel(), rand_texel()});
        end
        end_burst();
        drain_pixels();
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    // receiver back-pressure, with a long hold-off on request
    initial begin
        hold_taken = 0;
        hold_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_banner_pixel px;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual index %0d",
                         $realtime, o_pixel_index);
            end else begin
                px = pending_pixels.pop_front();
                check_field("pixel_index", PIX_W'(px.idx), PIX_W'(o_pixel_index));
                check_field("normal_pixel", px.norm, o_normal_pixel);
                check_field("highlight_pixel", px.high, o_highlight_pixel);
                check_field("last_of_item", PIX_W'(px.last), PIX_W'(o_last_of_item));
                check_field("banner_done", PIX_W'(px.done), PIX_W'(o_banner_done));
            end
        end
    end

    initial begin
        errors               = 0;
        hold_asked           = 0;
        tx_idle_pct          = 15;
        rx_idle_pct          = 61;
        small_mode           = 1'b0;
        pix_format           = FMT_RGB32;
        win_color            = 24'hFFFFFF;
        hil_color            = 24'h000000;
        tile_col             = 0;
        tile_row             = 0;
        quad_num             = 2'd0;
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_index          = CFG_SMALL_ICONS;
        i_cfg_data           = '0;
        i_in_valid           = 1'b0;
        i_texel_top_left     = '0;
        i_texel_top_right    = '0;
        i_texel_bottom_left  = '0;
        i_texel_bottom_right = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_quad({directed_rows[r].tl, directed_rows[r].tr,
                       directed_rows[r].bl, directed_rows[r].br},
                      directed_rows[r].typed, directed_rows[r].tl_norm,
                      directed_rows[r].tl_high);
        end
        end_burst();
        drain_pixels();

        apply_setting(1'b0, FMT_8BIT, 24'h000000, 24'hFFFFFF);
        run_quads(24, 5);
        apply_setting(1'b1, FMT_RGB565, 24'($urandom), 24'($urandom));
        run_quads(24);

        tx_idle_pct = 61;
        rx_idle_pct = 15;
        apply_setting(1'b1, FMT_RGB24, 24'hFFFFFF, 24'h000000);
        run_quads(24, -1, 12);
        apply_setting(1'b0, FMT_RGB32, 24'($urandom), 24'($urandom));
        run_quads(24);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting(1'b1, FMT_8BIT, 24'($urandom), 24'($urandom));
        run_quads(24);

        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rgb5a3b_pkg.sv
src/r5b_lane.sv
src/r5b_merge.sv
src/rgb5a3_banner_to_rgb_unit.sv
verif/tb_rgb5a3_banner_to_rgb_unit.sv
